FILE: src/bfha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants for the best-fit hole allocator
// Table sizing, request and status codes, result bundle and the saturating
// add used when holes are merged.
// ----------------------------------------------------------------------------
package bfha_pkg;

  // Table and address sizing
  localparam int unsigned MAX_HOLES  = 128;
  localparam int unsigned ADDR_WIDTH = 24;
  localparam int unsigned IDX_W      = $clog2(MAX_HOLES);
  localparam int unsigned CNT_W      = $clog2(MAX_HOLES + 1);

  // Port field widths
  localparam int unsigned FIELD_W    = 24;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STATUS_W   = 2;

  // APB register file
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // total_size after reset
  localparam logic [FIELD_W-1:0] TOTAL_SIZE_RST = FIELD_W'(8000000);

  // One hole entry in the table RAM: start in the upper half, length below
  localparam int unsigned ENTRY_W    = 2 * ADDR_WIDTH;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_INIT    = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  // Result bundle from the engine to the output register
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ADDR_WIDTH-1:0] address;
    logic [ADDR_WIDTH-1:0] largest;
  } res_t;

  // Add two lengths, clamp at all ones
  function automatic logic [ADDR_WIDTH-1:0] sat_add(input logic [ADDR_WIDTH-1:0] a,
                                                    input logic [ADDR_WIDTH-1:0] b);
    logic [ADDR_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_WIDTH] ? {ADDR_WIDTH{1'b1}} : s[ADDR_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/bfha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/bfha_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_engine: hole table sequencer; init and unused codes skip both walks
// Walks the table one entry per cycle through a single RAM read port for the
// best fit or the release neighbors, updates it, then rescans for the largest
// hole. A failed allocate, full table or zero-length release skip the rescan.
// ----------------------------------------------------------------------------
module bfha_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request side
  input  wire logic                           req_valid_i,
  output logic                                req_ready_o,
  input  wire logic [bfha_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [bfha_pkg::FIELD_W-1:0]   block_size_i,
  input  wire logic [bfha_pkg::FIELD_W-1:0]   block_start_i,
  // configuration
  input  wire logic [bfha_pkg::FIELD_W-1:0]   total_size_i,
  // result side
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output bfha_pkg::res_t                      res_o
);

  import bfha_pkg::*;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_REM_RD,
    ST_REM_WR,
    ST_MAX,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [REQ_W-1:0]      req_q, req_d;
  logic [ADDR_WIDTH-1:0] size_q, size_d;
  logic [ADDR_WIDTH-1:0] start_q, start_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ADDR_WIDTH-1:0] largest_q, largest_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [ADDR_WIDTH-1:0] addr_q, addr_d;
  // scan walker
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pend_idx_q, pend_idx_d;
  // best fit, or lower neighbor on release
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      sel_idx_q, sel_idx_d;
  logic [ADDR_WIDTH-1:0] sel_start_q, sel_start_d;
  logic [ADDR_WIDTH-1:0] sel_len_q, sel_len_d;
  // upper neighbor on release
  logic                  has_hi_q, has_hi_d;
  logic [IDX_W-1:0]      hi_idx_q, hi_idx_d;
  logic [ADDR_WIDTH-1:0] hi_len_q, hi_len_d;
  // slot to refill when a hole is removed
  logic [IDX_W-1:0]      tgt_idx_q, tgt_idx_d;
  logic [ADDR_WIDTH-1:0] max_q, max_d;

  // RAM port
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

  logic [ADDR_WIDTH-1:0] rd_start, rd_len;
  logic [ADDR_WIDTH:0]   rd_end, blk_end;
  logic [CNT_W-1:0]      count_m1;
  logic [IDX_W-1:0]      last_idx;
  logic                  lo_hit, hi_hit;

  bfha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_HOLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry fields and neighbor compares
  assign rd_start = ram_rdata[ENTRY_W-1:ADDR_WIDTH];
  assign rd_len   = ram_rdata[ADDR_WIDTH-1:0];
  assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
  assign blk_end  = {1'b0, start_q} + {1'b0, size_q};
  assign count_m1 = count_q - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign lo_hit   = !found_q && (rd_end == {1'b0, start_q});
  assign hi_hit   = !lo_hit && !has_hi_q && ({1'b0, rd_start} == blk_end);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    size_d      = size_q;
    start_d     = start_q;
    count_d     = count_q;
    largest_d   = largest_q;
    status_d    = status_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    sel_idx_d   = sel_idx_q;
    sel_start_d = sel_start_q;
    sel_len_d   = sel_len_q;
    has_hi_d    = has_hi_q;
    hi_idx_d    = hi_idx_q;
    hi_len_d    = hi_len_q;
    tgt_idx_d   = tgt_idx_q;
    max_d       = max_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      // first cycle after reset: seed entry 0 with the reset size
      ST_BOOT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {{ADDR_WIDTH{1'b0}}, ADDR_WIDTH'(TOTAL_SIZE_RST)};
        state_d   = ST_IDLE;
      end

      ST_IDLE: begin
        if (req_valid_i) begin
          req_d    = req_type_i;
          size_d   = ADDR_WIDTH'(block_size_i);
          start_d  = ADDR_WIDTH'(block_start_i);
          status_d = STAT_OK;
          addr_d   = '0;
          cnt_d    = '0;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          has_hi_d = 1'b0;
          if (req_type_i == REQ_ALLOC || req_type_i == REQ_RELEASE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_ACT;
          end
        end
      end

      // walk the table: issue one read, evaluate the previous one
      ST_SCAN: begin
        if (cnt_q < count_q) begin
          ram_re     = 1'b1;
          ram_raddr  = cnt_q[IDX_W-1:0];
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IDX_W-1:0];
          cnt_d      = cnt_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (req_q == REQ_ALLOC) begin
            if (rd_len >= size_q && (!found_q || rd_len <= sel_len_q)) begin
              found_d     = 1'b1;
              sel_idx_d   = pend_idx_q;
              sel_start_d = rd_start;
              sel_len_d   = rd_len;
            end
          end else begin
            if (lo_hit) begin
              found_d     = 1'b1;
              sel_idx_d   = pend_idx_q;
              sel_start_d = rd_start;
              sel_len_d   = rd_len;
            end
            if (hi_hit) begin
              has_hi_d = 1'b1;
              hi_idx_d = pend_idx_q;
              hi_len_d = rd_len;
            end
          end
        end
        if (cnt_q >= count_q && !pend_q) begin
          state_d = ST_ACT;
        end
      end

      // apply the request to the table
      ST_ACT: begin
        cnt_d   = '0;
        pend_d  = 1'b0;
        max_d   = '0;
        state_d = ST_MAX;
        case (req_q)
          REQ_ALLOC: begin
            if (!found_q) begin
              status_d = STAT_NO_FIT;
              state_d  = ST_DONE;
            end else begin
              addr_d = sel_start_q;
              if (sel_len_q == size_q) begin
                tgt_idx_d = sel_idx_q;
                state_d   = ST_REM_RD;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = sel_idx_q;
                ram_wdata = {sel_start_q + size_q, sel_len_q - size_q};
              end
            end
          end
          REQ_RELEASE: begin
            if (size_q == '0) begin
              state_d = ST_DONE;
            end else if (found_q && has_hi_q) begin
              ram_we    = 1'b1;
              ram_waddr = sel_idx_q;
              ram_wdata = {sel_start_q, sat_add(sat_add(sel_len_q, size_q), hi_len_q)};
              tgt_idx_d = hi_idx_q;
              state_d   = ST_REM_RD;
            end else if (found_q) begin
              ram_we    = 1'b1;
              ram_waddr = sel_idx_q;
              ram_wdata = {sel_start_q, sat_add(sel_len_q, size_q)};
            end else if (has_hi_q) begin
              ram_we    = 1'b1;
              ram_waddr = hi_idx_q;
              ram_wdata = {start_q, sat_add(hi_len_q, size_q)};
            end else if (count_q >= CNT_W'(MAX_HOLES)) begin
              status_d = STAT_FULL;
              state_d  = ST_DONE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IDX_W-1:0];
              ram_wdata = {start_q, size_q};
              count_d   = count_q + CNT_W'(1);
            end
          end
          REQ_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {{ADDR_WIDTH{1'b0}}, ADDR_WIDTH'(total_size_i)};
            count_d   = CNT_W'(1);
            largest_d = ADDR_WIDTH'(total_size_i);
            state_d   = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // remove a hole: fetch the last entry unless it is the one removed
      ST_REM_RD: begin
        if (tgt_idx_q == last_idx) begin
          count_d = count_m1;
          state_d = ST_MAX;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = last_idx;
          state_d   = ST_REM_WR;
        end
      end

      ST_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_idx_q;
        ram_wdata = ram_rdata;
        count_d   = count_m1;
        state_d   = ST_MAX;
      end

      // rescan for the largest hole
      ST_MAX: begin
        if (cnt_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[IDX_W-1:0];
          pend_d    = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && rd_len > max_q) begin
          max_d = rd_len;
        end
        if (cnt_q >= count_q && !pend_q) begin
          largest_d = max_q;
          state_d   = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_BOOT;
      count_q   <= CNT_W'(1);
      largest_q <= ADDR_WIDTH'(TOTAL_SIZE_RST);
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      largest_q <= largest_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    size_q      <= size_d;
    start_q     <= start_d;
    status_q    <= status_d;
    addr_q      <= addr_d;
    cnt_q       <= cnt_d;
    pend_idx_q  <= pend_idx_d;
    found_q     <= found_d;
    sel_idx_q   <= sel_idx_d;
    sel_start_q <= sel_start_d;
    sel_len_q   <= sel_len_d;
    has_hi_q    <= has_hi_d;
    hi_idx_q    <= hi_idx_d;
    hi_len_q    <= hi_len_d;
    tgt_idx_q   <= tgt_idx_d;
    max_q       <= max_d;
  end

  assign req_ready_o   = (state_q == ST_IDLE);
  assign res_valid_o   = (state_q == ST_DONE);
  assign res_o.status  = status_q;
  assign res_o.address = addr_q;
  assign res_o.largest = largest_q;

endmodule
`default_nettype wire

FILE: src/best_fit_hole_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_hole_allocator_top: best-fit free-hole allocator
// APB register for total_size, request/result channels, output register.
// ----------------------------------------------------------------------------
// Keeps up to 128 free holes in a one-write, one-read table RAM and serves one
// request at a time. An allocate or release walks the table once, one entry
// per cycle on the RAM read port, applies the change, and walks it again to
// recompute the largest hole. A failed allocate, a full table on release and
// a zero-length release skip the second walk; an init or an unused request
// code skips both walks. Right after reset the block writes the first hole
// before it takes a request. Results sit in an output register, so the next
// request is accepted while the previous result waits.
module best_fit_hole_allocator_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [bfha_pkg::REQ_W-1:0]      req_type_i,
  input  wire logic [bfha_pkg::FIELD_W-1:0]    block_size_i,
  input  wire logic [bfha_pkg::FIELD_W-1:0]    block_start_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [bfha_pkg::STATUS_W-1:0]   status_o,
  output logic      [bfha_pkg::FIELD_W-1:0]    address_o,
  output logic      [bfha_pkg::FIELD_W-1:0]    largest_free_o,
  // APB configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bfha_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bfha_pkg::PDATA_W-1:0]    pwdata,
  output logic      [bfha_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);

  import bfha_pkg::*;

  // register index, taken from paddr[2]
  localparam logic REG_TOTAL_SIZE = 1'b0;

  logic [FIELD_W-1:0] total_size_q;
  logic               res_valid, res_ready;
  res_t               res;
  res_t               out_q;
  logic               out_valid_q;
  logic               apb_wr;

  // Configuration register
  assign apb_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_size_q <= TOTAL_SIZE_RST;
    end else if (apb_wr) begin
      total_size_q <= pwdata[FIELD_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOTAL_SIZE) ? PDATA_W'(total_size_q) : '0;

  // Table sequencer
  bfha_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_ready_o   (in_ready_o),
    .req_type_i    (req_type_i),
    .block_size_i  (block_size_i),
    .block_start_i (block_start_i),
    .total_size_i  (total_size_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: takes a result whenever it is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign address_o      = FIELD_W'(out_q.address);
  assign largest_free_o = FIELD_W'(out_q.largest);

endmodule
`default_nettype wire
